### rtl/core/wiin_pkg.sv
// Shared types and constants for the weighted image normalizer.
// Holds the channel words, the configuration set and the arithmetic unit interface.
// No dependencies.
package wiin_pkg;

   localparam int SAMPLE_BITS = 32;

   localparam int Q_W = 48;
   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(48);
   localparam logic [STEP_W-1:0] RATIO_STEPS = STEP_W'(32);
   localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(16);

   localparam logic [15:0] TOLERANCE_RESET = 16'd6554;
   localparam logic [31:0] PSF_REF_PEAK_RESET = 32'd0;
   localparam logic ZERO_BELOW_RESET = 1'b0;
   localparam logic MASK_BELOW_RESET = 1'b1;

   localparam logic FUNC_MEASURE = 1'b0;
   localparam logic FUNC_NORMALIZE = 1'b1;

   typedef enum logic [1:0] {
      CSR_TOLERANCE    = 2'd0,
      CSR_PSF_REF_PEAK = 2'd1,
      CSR_ZERO_BELOW   = 2'd2,
      CSR_MASK_BELOW   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              func;
      logic              first_pixel;
      logic [31:0]       weight;
      logic signed [31:0] psf_value;
      logic signed [31:0] image_value;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] image_out;
      logic signed [31:0] psf_out;
      logic [15:0]       mask_out;
      logic              above_cutoff;
      logic signed [31:0] psf_peak;
      logic              error;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] tolerance;
      logic [31:0] psf_reference_peak;
      logic        zero_below_cutoff;
      logic        mask_below_cutoff;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic              is_sqrt;
      logic [STEP_W-1:0] steps;
      logic [31:0]       rem_init;
      logic [63:0]       src_init;
      logic [31:0]       divisor;
   } unit_cmd_type;

   typedef struct packed {
      logic           done;
      logic [Q_W-1:0] quotient;
   } unit_status_type;

endpackage

### rtl/core/wiin_csr.sv
// Configuration registers of the weighted image normalizer.
// Depends on wiin_pkg for the register indexes and the configuration struct.
module wiin_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  wiin_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata,
   output wiin_pkg::cfg_type      cfg
);

   wiin_pkg::cfg_type cfg_ff;
   wiin_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            wiin_pkg::CSR_TOLERANCE: begin
               cfg_in.tolerance = csr_wdata[15:0];
            end
            wiin_pkg::CSR_PSF_REF_PEAK: begin
               cfg_in.psf_reference_peak = csr_wdata;
            end
            wiin_pkg::CSR_ZERO_BELOW: begin
               cfg_in.zero_below_cutoff = csr_wdata[0];
            end
            wiin_pkg::CSR_MASK_BELOW: begin
               cfg_in.mask_below_cutoff = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance <= wiin_pkg::TOLERANCE_RESET;
         cfg_ff.psf_reference_peak <= wiin_pkg::PSF_REF_PEAK_RESET;
         cfg_ff.zero_below_cutoff <= wiin_pkg::ZERO_BELOW_RESET;
         cfg_ff.mask_below_cutoff <= wiin_pkg::MASK_BELOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/wiin_divsqrt.sv
// Shared iterative compare-subtract unit: restoring division or integer square root.
// Depends on wiin_pkg for the command and status structs.
module wiin_divsqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  wiin_pkg::unit_cmd_type    cmd,
   output wiin_pkg::unit_status_type status
);

   logic                          is_sqrt_ff, is_sqrt_in;
   logic [31:0]                   divisor_ff, divisor_in;
   logic [wiin_pkg::STEP_W-1:0]   count_ff, count_in;
   logic [31:0]                   rem_ff, rem_in;
   logic [63:0]                   src_ff, src_in;
   logic [wiin_pkg::Q_W-1:0]      q_ff, q_in;
   logic                          done_ff, done_in;

   logic [32:0] cand;
   logic [32:0] trial;
   logic [33:0] diff;
   logic        ge;

   always_comb begin
      if (is_sqrt_ff) begin
         cand = {rem_ff[30:0], src_ff[63:62]};
         trial = {15'b0, q_ff[15:0], 2'b01};
      end else begin
         cand = {rem_ff, src_ff[63]};
         trial = {1'b0, divisor_ff};
      end
      diff = {1'b0, cand} - {1'b0, trial};
      ge = ~diff[33];
   end

   always_comb begin
      is_sqrt_in = is_sqrt_ff;
      divisor_in = divisor_ff;
      count_in = count_ff;
      rem_in = rem_ff;
      src_in = src_ff;
      q_in = q_ff;
      done_in = done_ff;
      if (cmd.start) begin
         is_sqrt_in = cmd.is_sqrt;
         divisor_in = cmd.divisor;
         count_in = cmd.steps;
         rem_in = cmd.rem_init;
         src_in = cmd.src_init;
         q_in = '0;
         done_in = 1'b0;
      end else if (count_ff != '0) begin
         rem_in = ge ? diff[31:0] : cand[31:0];
         q_in = {q_ff[wiin_pkg::Q_W-2:0], ge};
         src_in = is_sqrt_ff ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
         count_in = count_ff - 1'b1;
         done_in = (count_ff == wiin_pkg::STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      is_sqrt_ff <= is_sqrt_in;
      divisor_ff <= divisor_in;
      rem_ff <= rem_in;
      src_ff <= src_in;
      q_ff <= q_in;
   end

   assign status.done = done_ff;
   assign status.quotient = q_ff;

endmodule

### rtl/core/weighted_image_normalizer_unit.sv
// Weighted image normalizer, Q16.16 fixed point. Depends on wiin_pkg, wiin_csr, wiin_divsqrt.
// The req channel takes one pixel word. A measure word (func 0) updates the weight and
// spread maxima in the cycle it is taken and gives no result; first_pixel reloads them.
// A normalize word (func 1) gives one rsp word: the image sample divided by its weight
// or by the maximum weight, the clean mask, the spread sample divided by its reference
// peak or measured maximum, the cutoff flag, the spread maximum and the error flag.
// Quotients saturate. A normalize word runs through one shared compare-subtract unit:
// image division (48 steps), weight ratio (32 steps), square root (16 steps), spread
// division (48 steps), through the states MUL, CMP, IMG, RATIO, SQRT, PSF and FINISH.
// The result word is registered as FINISH returns to IDLE, and a new request is taken
// only in IDLE, which a measure word never leaves. req_stall is high while a word is at work.
// If rsp_stall holds a previous word, the finished word waits until the output
// register frees up. The csr channel is always ready; write it only while idle.
// Reset is synchronous: maxima clear to zero, registers take their reset values
// (tolerance 0.1, reference peak 0, zeroing off, mask below cutoff on).
module weighted_image_normalizer_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  wiin_pkg::req_word_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output wiin_pkg::rsp_word_type  rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  wiin_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL    = 8'b0000_0010,
      ST_CMP    = 8'b0000_0100,
      ST_IMG    = 8'b0000_1000,
      ST_RATIO  = 8'b0001_0000,
      ST_SQRT   = 8'b0010_0000,
      ST_PSF    = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   localparam logic [63:0] SAT_MAX_MAG = (64'd1 << (wiin_pkg::SAMPLE_BITS - 1)) - 64'd1;

   function automatic logic [31:0] sat_quotient(
      input logic                     num_neg,
      input logic                     num_zero,
      input logic                     res_neg,
      input logic                     div_zero,
      input logic [wiin_pkg::Q_W-1:0] mag
   );
      logic [63:0] mag64;
      logic [63:0] val;
      begin
         mag64 = {{(64 - wiin_pkg::Q_W){1'b0}}, mag};
         if (div_zero) begin
            if (num_zero) begin
               val = '0;
            end else if (num_neg) begin
               val = ~SAT_MAX_MAG;
            end else begin
               val = SAT_MAX_MAG;
            end
         end else if (res_neg) begin
            val = (mag64 > SAT_MAX_MAG + 64'd1) ? ~SAT_MAX_MAG : (64'd0 - mag64);
         end else begin
            val = (mag64 > SAT_MAX_MAG) ? SAT_MAX_MAG : mag64;
         end
         return val[31:0];
      end
   endfunction

   wiin_pkg::cfg_type         cfg;
   wiin_pkg::unit_cmd_type    cmd;
   wiin_pkg::unit_status_type status;

   state_type state_ff, state_in;

   logic [31:0]        max_weight_ff, max_weight_in;
   logic signed [31:0] max_psf_ff, max_psf_in;
   logic [31:0]        weight_ff, weight_in;
   logic signed [31:0] psf_ff, psf_in;
   logic signed [31:0] img_ff, img_in;
   logic [47:0]        prod_ff, prod_in;
   logic               above_ff, above_in;
   logic [31:0]        img_res_ff, img_res_in;
   logic [15:0]        mask_ff, mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   wiin_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic        above_now;
   logic [31:0] img_div;
   logic [31:0] img_mag;
   logic [31:0] psf_mag;
   logic [31:0] ratio_now;
   logic [31:0] sqrt_src;
   logic        den_from_max;
   logic        den_neg;
   logic        den_zero;
   logic [31:0] den_mag;
   logic [31:0] psf_res;
   logic        out_free;

   wiin_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wiin_divsqrt u_divsqrt (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      above_now = {weight_ff, 16'b0} > prod_ff;
      img_div = above_ff ? weight_ff : max_weight_ff;
      img_mag = img_ff[31] ? (~img_ff + 32'd1) : img_ff;
      psf_mag = psf_ff[31] ? (~psf_ff + 32'd1) : psf_ff;
      ratio_now = (weight_ff >= max_weight_ff) ? 32'hFFFF_FFFF : status.quotient[31:0];
      sqrt_src = above_ff ? ratio_now : {cfg.tolerance, 16'b0};
      den_from_max = (cfg.psf_reference_peak == 32'd0);
      den_neg = den_from_max && max_psf_ff[31];
      den_zero = den_from_max && (max_psf_ff == 32'sd0);
      if (!den_from_max) begin
         den_mag = cfg.psf_reference_peak;
      end else if (max_psf_ff[31]) begin
         den_mag = ~max_psf_ff + 32'd1;
      end else begin
         den_mag = max_psf_ff;
      end
      psf_res = sat_quotient(psf_ff[31], psf_ff == 32'sd0, psf_ff[31] ^ den_neg, den_zero,
                             status.quotient);
   end

   always_comb begin
      state_in = state_ff;
      max_weight_in = max_weight_ff;
      max_psf_in = max_psf_ff;
      weight_in = weight_ff;
      psf_in = psf_ff;
      img_in = img_ff;
      prod_in = prod_ff;
      above_in = above_ff;
      img_res_in = img_res_ff;
      mask_in = mask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               weight_in = req_data.weight;
               psf_in = req_data.psf_value;
               img_in = req_data.image_value;
               if (req_data.func == wiin_pkg::FUNC_MEASURE) begin
                  if (req_data.first_pixel) begin
                     max_weight_in = req_data.weight;
                     max_psf_in = req_data.psf_value;
                  end else begin
                     if (req_data.weight > max_weight_ff) begin
                        max_weight_in = req_data.weight;
                     end
                     if (req_data.psf_value > max_psf_ff) begin
                        max_psf_in = req_data.psf_value;
                     end
                  end
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in = {32'b0, cfg.tolerance} * {16'b0, max_weight_ff};
            state_in = ST_CMP;
         end
         ST_CMP: begin
            above_in = above_now;
            cmd.start = 1'b1;
            cmd.is_sqrt = 1'b0;
            cmd.steps = wiin_pkg::DIV_STEPS;
            cmd.rem_init = '0;
            cmd.src_init = {img_mag, 32'b0};
            cmd.divisor = above_now ? weight_ff : max_weight_ff;
            state_in = ST_IMG;
         end
         ST_IMG: begin
            if (status.done) begin
               if (!above_ff && cfg.zero_below_cutoff) begin
                  img_res_in = '0;
               end else begin
                  img_res_in = sat_quotient(img_ff[31], img_ff == 32'sd0, img_ff[31],
                                            img_div == 32'd0, status.quotient);
               end
               cmd.start = 1'b1;
               cmd.is_sqrt = 1'b0;
               cmd.steps = wiin_pkg::RATIO_STEPS;
               cmd.rem_init = weight_ff;
               cmd.src_init = '0;
               cmd.divisor = max_weight_ff;
               state_in = ST_RATIO;
            end
         end
         ST_RATIO: begin
            if (status.done) begin
               cmd.start = 1'b1;
               cmd.is_sqrt = 1'b1;
               cmd.steps = wiin_pkg::SQRT_STEPS;
               cmd.rem_init = '0;
               cmd.src_init = {sqrt_src, 32'b0};
               cmd.divisor = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (status.done) begin
               mask_in = (!above_ff && cfg.mask_below_cutoff) ? 16'd0 : status.quotient[15:0];
               cmd.start = 1'b1;
               cmd.is_sqrt = 1'b0;
               cmd.steps = wiin_pkg::DIV_STEPS;
               cmd.rem_init = '0;
               cmd.src_init = {psf_mag, 32'b0};
               cmd.divisor = den_mag;
               state_in = ST_PSF;
            end
         end
         ST_PSF: begin
            if (status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.image_out = img_res_ff;
               rsp_data_in.psf_out = psf_res;
               rsp_data_in.mask_out = mask_ff;
               rsp_data_in.above_cutoff = above_ff;
               rsp_data_in.psf_peak = max_psf_ff;
               rsp_data_in.error = (max_weight_ff == 32'd0) || den_zero || den_neg;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         max_weight_ff <= '0;
         max_psf_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         max_weight_ff <= max_weight_in;
         max_psf_ff <= max_psf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      weight_ff <= weight_in;
      psf_ff <= psf_in;
      img_ff <= img_in;
      prod_ff <= prod_in;
      above_ff <= above_in;
      img_res_ff <= img_res_in;
      mask_ff <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

### test/tb_weighted_image_normalizer_unit.sv
// Self-checking testbench for weighted_image_normalizer_unit: measure and normalize pixel words
// are checked against a predictor of the Q16.16 division, mask and cutoff arithmetic.
// Depends on wiin_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_weighted_image_normalizer_unit;

   localparam longint SAT_HI = (64'sd1 <<< (wiin_pkg::SAMPLE_BITS - 1)) - 64'sd1;
   localparam longint SAT_LO = -SAT_HI - 64'sd1;
   localparam int SETTLE_CYCLES = 160;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int SEGMENT_ITEMS = 97;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   wiin_pkg::req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   wiin_pkg::rsp_word_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   wiin_pkg::csr_index_type csr_index = wiin_pkg::CSR_TOLERANCE;
   logic [31:0] csr_wdata = '0;

   wiin_pkg::req_word_type pixel_q[$];
   wiin_pkg::rsp_word_type expected_q[$];
   logic req_taken = 1'b0;
   int idle_pct = 0;
   int stall_pct = 0;
   int fail_count = 0;
   int pushed = 0;
   int unsigned cycle_count = 0;

   logic [15:0] cfg_tolerance = wiin_pkg::TOLERANCE_RESET;
   logic [31:0] cfg_ref_peak = wiin_pkg::PSF_REF_PEAK_RESET;
   logic cfg_zero_below = wiin_pkg::ZERO_BELOW_RESET;
   logic cfg_mask_below = wiin_pkg::MASK_BELOW_RESET;
   logic [31:0] max_weight = '0;
   logic signed [31:0] max_psf = '0;

   weighted_image_normalizer_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint fixed_div(input logic signed [31:0] num, input longint den);
      longint scaled;
      longint quo;
      scaled = longint'(num) * 64'sd65536;
      if (den == 0) begin
         if (scaled > 0) return SAT_HI;
         if (scaled < 0) return SAT_LO;
         return 0;
      end
      quo = scaled / den;
      if (quo > SAT_HI) return SAT_HI;
      if (quo < SAT_LO) return SAT_LO;
      return quo;
   endfunction

   function automatic logic [31:0] int_sqrt(input logic [63:0] val);
      logic [63:0] rest;
      logic [63:0] root;
      logic [63:0] probe;
      rest = val;
      root = '0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rest) probe = probe >> 2;
      while (probe != 0) begin
         if (rest >= root + probe) begin
            rest = rest - root - probe;
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[31:0];
   endfunction

   function automatic bit predict_pixel(input wiin_pkg::req_word_type px,
                                        output wiin_pkg::rsp_word_type res);
      logic [63:0] ratio;
      longint img_q;
      longint psf_q;
      longint den;
      logic [31:0] mask;
      bit err;
      bit above;
      res = '0;
      if (px.func == wiin_pkg::FUNC_MEASURE) begin
         if (px.first_pixel) begin
            max_weight = px.weight;
            max_psf = $signed(px.psf_value);
         end else begin
            if (px.weight > max_weight) max_weight = px.weight;
            if ($signed(px.psf_value) > max_psf) max_psf = $signed(px.psf_value);
         end
         return 1'b0;
      end
      err = (max_weight == 0);
      above = {16'd0, px.weight, 16'd0} > (64'(cfg_tolerance) * 64'(max_weight));
      if (above) begin
         img_q = fixed_div(px.image_value, longint'({32'd0, px.weight}));
         if (max_weight == 0) begin
            ratio = 64'hFFFF_FFFF;
         end else begin
            ratio = {px.weight, 32'd0} / {32'd0, max_weight};
            if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
         end
         mask = int_sqrt(ratio);
      end else begin
         if (cfg_zero_below) img_q = 0;
         else img_q = fixed_div(px.image_value, longint'({32'd0, max_weight}));
         if (cfg_mask_below) mask = '0;
         else mask = int_sqrt({32'd0, cfg_tolerance, 16'd0});
      end
      if (cfg_ref_peak != 0) den = longint'({32'd0, cfg_ref_peak});
      else den = longint'(max_psf);
      if (den <= 0) err = 1'b1;
      psf_q = fixed_div(px.psf_value, den);
      res.image_out = img_q[31:0];
      res.psf_out = psf_q[31:0];
      res.mask_out = mask[15:0];
      res.above_cutoff = above;
      res.psf_peak = max_psf;
      res.error = err;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (fail_count < 40) begin
         $display("mismatch on %s at cycle %0d: got %h, expected %h", what, cycle_count,
                  got, want);
      end
      fail_count++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (!req_valid || req_taken) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_data <= pixel_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      wiin_pkg::rsp_word_type pred;
      wiin_pkg::rsp_word_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            if (predict_pixel(req_data, pred)) expected_q.push_back(pred);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result word", rsp_data.image_out, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.image_out !== want.image_out)
                  report_mismatch("image_out", rsp_data.image_out, want.image_out);
               if (rsp_data.psf_out !== want.psf_out)
                  report_mismatch("psf_out", rsp_data.psf_out, want.psf_out);
               if (rsp_data.mask_out !== want.mask_out)
                  report_mismatch("mask_out", 32'(rsp_data.mask_out), 32'(want.mask_out));
               if (rsp_data.above_cutoff !== want.above_cutoff)
                  report_mismatch("above_cutoff", 32'(rsp_data.above_cutoff),
                                  32'(want.above_cutoff));
               if (rsp_data.psf_peak !== want.psf_peak)
                  report_mismatch("psf_peak", rsp_data.psf_peak, want.psf_peak);
               if (rsp_data.error !== want.error)
                  report_mismatch("error", 32'(rsp_data.error), 32'(want.error));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic push_pixel(input logic func, input logic first, input logic [31:0] w,
                             input logic [31:0] psf, input logic [31:0] img);
      wiin_pkg::req_word_type px;
      px.func = func;
      px.first_pixel = first;
      px.weight = w;
      px.psf_value = psf;
      px.image_value = img;
      pixel_q.push_back(px);
      pushed++;
   endtask

   task automatic csr_write(input wiin_pkg::csr_index_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         wiin_pkg::CSR_TOLERANCE: cfg_tolerance = val[15:0];
         wiin_pkg::CSR_PSF_REF_PEAK: cfg_ref_peak = val;
         wiin_pkg::CSR_ZERO_BELOW: cfg_zero_below = val[0];
         wiin_pkg::CSR_MASK_BELOW: cfg_mask_below = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pixel_q.size() != 0 || req_valid || expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4, 5: return $urandom_range(32'h0004_0000);
         6: return -$urandom_range(32'h0004_0000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] norm_weight(input logic [31:0] peak);
      case ($urandom_range(5))
         0: return pick_value();
         1: return peak >> $urandom_range(6);
         2: return peak;
         3: return $urandom_range(peak, 0);
         default: return (peak / 10) + $urandom_range(3) - 2;
      endcase
   endfunction

   task automatic add_frame();
      logic [31:0] peak;
      logic [31:0] w;
      logic [31:0] psf;
      int n_meas;
      int n_norm;
      bit zero_frame;
      bit neg_frame;
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            push_pixel(1'($urandom_range(1)), 1'($urandom_range(1)), pick_value(),
                       pick_value(), pick_value());
         end
         return;
      end
      n_meas = $urandom_range(5);
      n_norm = $urandom_range(1, 6);
      zero_frame = ($urandom_range(15) == 0);
      neg_frame = ($urandom_range(7) == 0);
      peak = '0;
      for (int k = 0; k <= n_meas; k++) begin
         w = zero_frame ? 32'd0 : pick_value();
         if (k == 0 || w > peak) peak = w;
         psf = neg_frame ? (pick_value() | 32'h8000_0000) : pick_value();
         push_pixel(wiin_pkg::FUNC_MEASURE, k == 0, w, psf, pick_value());
      end
      for (int k = 0; k < n_norm; k++) begin
         push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'($urandom_range(1)), norm_weight(peak),
                    pick_value(), pick_value());
      end
   endtask

   initial begin
      logic [31:0] tol_val;
      logic [31:0] ref_val;
      logic [31:0] zero_val;
      logic [31:0] mask_val;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'h0005_0000, 32'h0003_0000, 32'h0002_0000);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'h0000_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
      push_pixel(wiin_pkg::FUNC_MEASURE, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'h1234_5678);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'd6554, 32'h0001_0000, 32'h0001_0000);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'd6555, 32'h0001_0000, 32'h0001_0000);
      push_pixel(wiin_pkg::FUNC_MEASURE, 1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
      push_pixel(wiin_pkg::FUNC_MEASURE, 1'b0, 32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b1, 32'h0001_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      push_pixel(wiin_pkg::FUNC_MEASURE, 1'b1, 32'h0000_0100, 32'hFFFB_0000, 32'h0000_0000);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'hFFFF_FFFF, 32'h0003_0000, 32'h1234_5678);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'h0000_0080, 32'h8000_0000, 32'hFFFF_FFFF);
      push_pixel(wiin_pkg::FUNC_MEASURE, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'h0000_0000, 32'h0000_0005, 32'h0000_0005);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'h0000_0003, 32'hFFFF_FFFB, 32'hFFFF_FFFB);
      push_pixel(wiin_pkg::FUNC_MEASURE, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
      push_pixel(wiin_pkg::FUNC_NORMALIZE, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      wait_idle();

      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0: begin
               tol_val = 0; ref_val = 0; zero_val = 1; mask_val = 0;
            end
            1: begin
               tol_val = 32'hFFFF; ref_val = 32'hFFFF_FFFF; zero_val = 0; mask_val = 0;
            end
            2: begin
               tol_val = 6554; ref_val = 32'h0001_0000; zero_val = 0; mask_val = 1;
            end
            4: begin
               tol_val = 32768; ref_val = 0; zero_val = 1; mask_val = 1;
            end
            default: begin
               tol_val = $urandom_range(32'hFFFF);
               ref_val = $urandom_range(1) ? 32'd0 : pick_value();
               zero_val = $urandom();
               mask_val = $urandom();
            end
         endcase
         csr_write(wiin_pkg::CSR_TOLERANCE, tol_val);
         csr_write(wiin_pkg::CSR_PSF_REF_PEAK, ref_val);
         csr_write(wiin_pkg::CSR_ZERO_BELOW, zero_val);
         csr_write(wiin_pkg::CSR_MASK_BELOW, mask_val);
         case (seg % 4)
            0: begin
               idle_pct = 0; stall_pct = 0;
            end
            1: begin
               idle_pct = 53; stall_pct = 0;
            end
            2: begin
               idle_pct = 0; stall_pct = 53;
            end
            default: begin
               idle_pct = 38; stall_pct = 38;
            end
         endcase
         pushed = 0;
         while (pushed < SEGMENT_ITEMS) add_frame();
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
